// File: rtl/core/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold on every clock edge out of reset
`define BGGI_CHECK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bggi check failed");
// condition must never be seen on a clock edge out of reset
`define BGGI_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("bggi forbidden condition seen");
`else
`define BGGI_CHECK(label, clk, rst_n, prop)
`define BGGI_NEVER(label, clk, rst_n, cond)
`endif

`endif

// File: rtl/core/bggi_pkg.sv
package bggi_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = 7;
    localparam int IDX_W       = 6;
    localparam int T_W         = FRAC_BITS + 2;
    localparam int P_W         = 2 * DATA_W;
    localparam int HI_W        = P_W - 2 * FRAC_BITS;
    localparam int DEF_MAX_NX  = 64;
    localparam int DEF_MAX_NY  = 64;
    localparam int QUEUE_DEPTH = 4;

    localparam int IN_TDATA_W  = ((2 * IDX_W + 4 * DATA_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 2 * DATA_W;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_X = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_Y = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_X    = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y    = CFG_IDX_W'(5);

    localparam logic [DATA_W-1:0] INV_STEP_RST = DATA_W'(1) << FRAC_BITS;
    localparam logic [CNT_W-1:0]  CELLS_RST    = CNT_W'(64);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic signed [DATA_W-1:0] origin_x;
        logic signed [DATA_W-1:0] origin_y;
        logic [DATA_W-1:0]        inv_step_x;
        logic [DATA_W-1:0]        inv_step_y;
        logic [CNT_W-1:0]         cells_x;
        logic [CNT_W-1:0]         cells_y;
    } cfg_t;

    // one classified word between front and back
    typedef struct packed {
        logic                     op;
        logic                     oor;
        logic                     wr_ok;
        logic [IDX_W-1:0]         col;
        logic [IDX_W-1:0]         row;
        logic signed [DATA_W-1:0] value_dx;
        logic signed [DATA_W-1:0] value_dy;
        logic [CNT_W-1:0]         lx;
        logic [CNT_W-1:0]         ly;
        logic [T_W-1:0]           tx;
        logic [T_W-1:0]           ty;
    } q_item_t;

endpackage

// File: rtl/core/bggi_front.sv
module bggi_front #(
    parameter int MAX_NX = bggi_pkg::DEF_MAX_NX,
    parameter int MAX_NY = bggi_pkg::DEF_MAX_NY
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  bggi_pkg::cfg_t                    cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              in_op,
    input  logic [bggi_pkg::IDX_W-1:0]        in_col,
    input  logic [bggi_pkg::IDX_W-1:0]        in_row,
    input  logic signed [bggi_pkg::DATA_W-1:0] in_vdx,
    input  logic signed [bggi_pkg::DATA_W-1:0] in_vdy,
    input  logic signed [bggi_pkg::DATA_W-1:0] in_qx,
    input  logic signed [bggi_pkg::DATA_W-1:0] in_qy,
    output logic                              q_push,
    output bggi_pkg::q_item_t                 q_item,
    input  logic                              q_full
);
    import bggi_pkg::*;

    typedef struct packed {
        logic             oor;
        logic [CNT_W-1:0] lo;
        logic [T_W-1:0]   t;
    } axis_t;

    function automatic logic [CNT_W-1:0] eff_cells(logic [CNT_W-1:0] c, int maxn);
        if (c < CNT_W'(2)) return CNT_W'(2);
        if (32'(c) > 32'(maxn)) return CNT_W'(maxn);
        return c;
    endfunction

    // cell index and fraction along one axis, upper edge folded one cell in
    function automatic axis_t locate(logic neg, logic [P_W-1:0] p, logic [CNT_W-1:0] n);
        logic [HI_W-1:0]  hi;
        logic [CNT_W-1:0] nm2;
        logic [1:0]       ext;
        axis_t            r;
        hi    = p[P_W-1:2*FRAC_BITS];
        nm2   = n - CNT_W'(2);
        ext   = hi[1:0] - nm2[1:0];
        r.oor = neg || (hi > HI_W'(n))
                || ((hi == HI_W'(n)) && (p[2*FRAC_BITS-1:0] != '0));
        if (hi > HI_W'(nm2)) begin
            r.lo = nm2;
            r.t  = {ext, p[2*FRAC_BITS-1:FRAC_BITS]};
        end else begin
            r.lo = hi[CNT_W-1:0];
            r.t  = {2'b00, p[2*FRAC_BITS-1:FRAC_BITS]};
        end
        return r;
    endfunction

    logic adv;
    logic a_valid_reg, b_valid_reg;

    logic                     a_op_reg;
    logic [IDX_W-1:0]         a_col_reg, a_row_reg;
    logic signed [DATA_W-1:0] a_vdx_reg, a_vdy_reg;
    logic signed [DATA_W:0]   a_dx_reg, a_dy_reg;

    logic                     b_op_reg;
    logic [IDX_W-1:0]         b_col_reg, b_row_reg;
    logic signed [DATA_W-1:0] b_vdx_reg, b_vdy_reg;
    logic                     b_negx_reg, b_negy_reg;
    logic [P_W-1:0]           b_px_reg, b_py_reg;

    logic [CNT_W-1:0] nx, ny;
    axis_t            ax, ay;
    logic             is_query;

    assign adv      = !b_valid_reg || !q_full;
    assign in_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    // stage a: offset from origin, stage b: scale by inverse step
    always_ff @(posedge aclk) begin
        if (adv) begin
            a_op_reg   <= in_op;
            a_col_reg  <= in_col;
            a_row_reg  <= in_row;
            a_vdx_reg  <= in_vdx;
            a_vdy_reg  <= in_vdy;
            a_dx_reg   <= (DATA_W+1)'(in_qx) - (DATA_W+1)'(cfg.origin_x);
            a_dy_reg   <= (DATA_W+1)'(in_qy) - (DATA_W+1)'(cfg.origin_y);
            b_op_reg   <= a_op_reg;
            b_col_reg  <= a_col_reg;
            b_row_reg  <= a_row_reg;
            b_vdx_reg  <= a_vdx_reg;
            b_vdy_reg  <= a_vdy_reg;
            b_negx_reg <= a_dx_reg[DATA_W];
            b_negy_reg <= a_dy_reg[DATA_W];
            b_px_reg   <= P_W'(a_dx_reg[DATA_W-1:0]) * P_W'(cfg.inv_step_x);
            b_py_reg   <= P_W'(a_dy_reg[DATA_W-1:0]) * P_W'(cfg.inv_step_y);
        end
    end

    always_comb begin
        nx       = eff_cells(cfg.cells_x, MAX_NX);
        ny       = eff_cells(cfg.cells_y, MAX_NY);
        ax       = locate(b_negx_reg, b_px_reg, nx);
        ay       = locate(b_negy_reg, b_py_reg, ny);
        is_query = (b_op_reg == OP_QUERY);

        q_item.op       = b_op_reg;
        q_item.oor      = is_query && (ax.oor || ay.oor);
        q_item.wr_ok    = (32'(b_col_reg) < 32'(MAX_NX)) && (32'(b_row_reg) < 32'(MAX_NY));
        q_item.col      = b_col_reg;
        q_item.row      = b_row_reg;
        q_item.value_dx = b_vdx_reg;
        q_item.value_dy = b_vdy_reg;
        q_item.lx       = ax.lo;
        q_item.ly       = ay.lo;
        q_item.tx       = ax.t;
        q_item.ty       = ay.t;
        q_push          = b_valid_reg && !q_full;
    end

endmodule

// File: rtl/core/bggi_fifo.sv
module bggi_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  bggi_pkg::q_item_t push_item,
    output logic              full,
    input  logic              pop,
    output bggi_pkg::q_item_t head_item,
    output logic              empty
);
    import bggi_pkg::*;

    // depth is a power of two so the pointers wrap on their own
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CQ_W  = $clog2(QUEUE_DEPTH + 1);

    q_item_t          slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CQ_W-1:0]  count_reg;

    assign full      = (count_reg == CQ_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            if (push && !pop)      count_reg <= count_reg + CQ_W'(1);
            else if (pop && !push) count_reg <= count_reg - CQ_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// File: rtl/core/bggi_back.sv
module bggi_back #(
    parameter int MAX_NX = bggi_pkg::DEF_MAX_NX,
    parameter int MAX_NY = bggi_pkg::DEF_MAX_NY
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_empty,
    input  bggi_pkg::q_item_t                   q_item,
    output logic                                q_pop,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [bggi_pkg::OUT_TDATA_W-1:0]    out_data,
    output logic                                out_oor,
    output logic                                busy
);
    import bggi_pkg::*;

    localparam int DEPTH = MAX_NX * MAX_NY;
    localparam int AW    = $clog2(DEPTH);
    localparam int DIF_W = DATA_W + 1;
    localparam int TS_W  = T_W + 1;
    localparam int XP_W  = DIF_W + TS_W;
    localparam int R_W   = DATA_W + 3;
    localparam int YD_W  = R_W + 1;
    localparam int YP_W  = YD_W + TS_W;
    localparam int V_W   = DATA_W + 5;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_READ = 4'd1;
    localparam logic [3:0] ST_WAIT = 4'd2;
    localparam logic [3:0] ST_XDIF = 4'd3;
    localparam logic [3:0] ST_XMUL = 4'd4;
    localparam logic [3:0] ST_XADD = 4'd5;
    localparam logic [3:0] ST_YDIF = 4'd6;
    localparam logic [3:0] ST_YMUL = 4'd7;
    localparam logic [3:0] ST_YADD = 4'd8;
    localparam logic [3:0] ST_DONE = 4'd9;

    function automatic logic [DATA_W-1:0] sat32(logic signed [V_W-1:0] v);
        logic [V_W-DATA_W:0] upper;
        upper = v[V_W-1:DATA_W-1];
        if ((&upper) || !(|upper)) return v[DATA_W-1:0];
        if (v[V_W-1]) return {1'b1, {(DATA_W-1){1'b0}}};
        return {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

    logic [3:0]       state_reg, state_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             rd_pend_reg;
    logic [1:0]       rd_idx_reg;
    logic [CNT_W-1:0] lx_reg, ly_reg;
    logic [T_W-1:0]   tx_reg, ty_reg;

    // gradient store: {dy, dx} per grid point, row-major
    logic [2*DATA_W-1:0] store_reg [DEPTH];
    logic [2*DATA_W-1:0] rd_data_reg;
    logic [2*DATA_W-1:0] corner_reg [4];

    logic signed [DIF_W-1:0] xdif_reg  [4];
    logic signed [XP_W-1:0]  xprod_reg [4];
    logic signed [R_W-1:0]   r_reg     [4];
    logic signed [YD_W-1:0]  ydif_reg  [2];
    logic signed [YP_W-1:0]  yprod_reg [2];
    logic signed [V_W-1:0]   v_reg     [2];

    logic                   out_valid_reg, out_oor_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic          out_free;
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic          out_load, out_oor_load;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_oor   = out_oor_reg;
    assign busy      = (state_reg != ST_IDLE);

    assign mem_waddr = AW'(32'(q_item.row) * 32'(MAX_NX) + 32'(q_item.col));
    // corner order: bit 0 steps x, bit 1 steps y
    assign mem_raddr = AW'((32'(ly_reg) + 32'(cnt_reg[1])) * 32'(MAX_NX)
                           + 32'(lx_reg) + 32'(cnt_reg[0]));

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        q_pop        = 1'b0;
        mem_we       = 1'b0;
        out_load     = 1'b0;
        out_oor_load = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    if (q_item.op == OP_WRITE) begin
                        q_pop  = 1'b1;
                        mem_we = q_item.wr_ok;
                    end else if (q_item.oor) begin
                        if (out_free) begin
                            q_pop        = 1'b1;
                            out_load     = 1'b1;
                            out_oor_load = 1'b1;
                        end
                    end else begin
                        q_pop      = 1'b1;
                        cnt_next   = '0;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                cnt_next = cnt_reg + 2'd1;
                if (&cnt_reg) state_next = ST_WAIT;
            end
            ST_WAIT: state_next = ST_XDIF;
            ST_XDIF: state_next = ST_XMUL;
            ST_XMUL: state_next = ST_XADD;
            ST_XADD: state_next = ST_YDIF;
            ST_YDIF: state_next = ST_YMUL;
            ST_YMUL: state_next = ST_YADD;
            ST_YADD: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rd_pend_reg <= (state_reg == ST_READ);
            if (out_load)       out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) store_reg[mem_waddr] <= {q_item.value_dy, q_item.value_dx};
        rd_data_reg <= store_reg[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= cnt_reg;
        if (state_reg == ST_IDLE && q_pop) begin
            lx_reg <= q_item.lx;
            ly_reg <= q_item.ly;
            tx_reg <= q_item.tx;
            ty_reg <= q_item.ty;
        end
        if (rd_pend_reg) corner_reg[rd_idx_reg] <= rd_data_reg;

        // x pass: lane 2*c+r is component c (dx, dy) on row r
        for (int c = 0; c < 2; c++) begin
            for (int r = 0; r < 2; r++) begin
                if (state_reg == ST_XDIF) begin
                    xdif_reg[2*c+r] <=
                        DIF_W'($signed(corner_reg[2*r+1][c*DATA_W +: DATA_W]))
                        - DIF_W'($signed(corner_reg[2*r][c*DATA_W +: DATA_W]));
                end
                if (state_reg == ST_XMUL) begin
                    xprod_reg[2*c+r] <= XP_W'(xdif_reg[2*c+r])
                                        * XP_W'($signed({1'b0, tx_reg}));
                end
                if (state_reg == ST_XADD) begin
                    r_reg[2*c+r] <= R_W'(
                        XP_W'($signed(corner_reg[2*r][c*DATA_W +: DATA_W]))
                        + (xprod_reg[2*c+r] >>> FRAC_BITS));
                end
            end
        end

        // y pass between the two row results
        for (int c = 0; c < 2; c++) begin
            if (state_reg == ST_YDIF)
                ydif_reg[c] <= YD_W'(r_reg[2*c+1]) - YD_W'(r_reg[2*c]);
            if (state_reg == ST_YMUL)
                yprod_reg[c] <= YP_W'(ydif_reg[c]) * YP_W'($signed({1'b0, ty_reg}));
            if (state_reg == ST_YADD)
                v_reg[c] <= V_W'(YP_W'(r_reg[2*c]) + (yprod_reg[c] >>> FRAC_BITS));
        end

        if (out_load) begin
            out_oor_reg  <= out_oor_load;
            out_data_reg <= out_oor_load ? '0 : {sat32(v_reg[1]), sat32(v_reg[0])};
        end
    end

endmodule

// File: rtl/core/bilinear_gradient_grid_interp_core.sv
// bilinear gradient grid interpolator
// input words arrive on s_tvalid/s_tready; s_tuser is the opcode (write a
// grid sample or query a point). a write stores (value_dx, value_dy) at
// (entry_col, entry_row) and returns nothing; a query returns one word on
// m_tvalid/m_tready with the interpolated gradients and an out-of-range flag.
// grid origin, inverse spacing and cell counts come in on cfg_we/cfg_index/
// cfg_data and are only changed while the block is idle, which the user must
// ensure, as the block does not. a two-stage front computes the cell index
// and fraction (one 32x32 multiply per axis) and drops classified words into
// a four-entry queue; the back sequencer drains the queue against a gradient
// store with one read and one write port. a write or an out-of-range query
// is popped in the idle state; an in-range query runs four corner reads
// through the one store read port, one read wait, then x and y blend steps of
// subtract, multiply and add; the back pops no new word until it is done.
// reset clears the config to origin 0, step 1.0, 64x64 points and empties the
// pipeline; the store is not cleared, so samples must be written before use.
// when m_tready is low the result waits in the output register while the
// queue keeps filling; s_tready drops once the queue and the front output are full.
`include "assert_macros.svh"

module bilinear_gradient_grid_interp_core #(
    parameter int MAX_NX = bggi_pkg::DEF_MAX_NX,
    parameter int MAX_NY = bggi_pkg::DEF_MAX_NY
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // config write port
    input  logic                               cfg_we,
    input  logic [bggi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bggi_pkg::DATA_W-1:0]        cfg_data,
    // input words
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // entry_col, entry_row, value_dx, value_dy, query_x, query_y, zero pad
    input  logic [bggi_pkg::IN_TDATA_W-1:0]    s_tdata,
    // opcode
    input  logic                               s_tuser,
    // result words
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // grad_x, grad_y
    output logic [bggi_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // out_of_range
    output logic                               m_tuser
);
    import bggi_pkg::*;

    cfg_t    cfg_reg;
    logic    q_push, q_full, q_pop, q_empty;
    q_item_t q_in, q_head;
    logic    back_busy;

    // config registers, held between queries
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin_x   <= '0;
            cfg_reg.origin_y   <= '0;
            cfg_reg.inv_step_x <= INV_STEP_RST;
            cfg_reg.inv_step_y <= INV_STEP_RST;
            cfg_reg.cells_x    <= CELLS_RST;
            cfg_reg.cells_y    <= CELLS_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ORIGIN_X:   cfg_reg.origin_x   <= cfg_data;
                REG_ORIGIN_Y:   cfg_reg.origin_y   <= cfg_data;
                REG_INV_STEP_X: cfg_reg.inv_step_x <= cfg_data;
                REG_INV_STEP_Y: cfg_reg.inv_step_y <= cfg_data;
                REG_CELLS_X:    cfg_reg.cells_x    <= cfg_data[CNT_W-1:0];
                REG_CELLS_Y:    cfg_reg.cells_y    <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // front: offset, scale, locate cell and fraction
    bggi_front #(
        .MAX_NX (MAX_NX),
        .MAX_NY (MAX_NY)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_op    (s_tuser),
        .in_col   (s_tdata[IDX_W-1:0]),
        .in_row   (s_tdata[2*IDX_W-1:IDX_W]),
        .in_vdx   (s_tdata[2*IDX_W +: DATA_W]),
        .in_vdy   (s_tdata[2*IDX_W+DATA_W +: DATA_W]),
        .in_qx    (s_tdata[2*IDX_W+2*DATA_W +: DATA_W]),
        .in_qy    (s_tdata[2*IDX_W+3*DATA_W +: DATA_W]),
        .q_push   (q_push),
        .q_item   (q_in),
        .q_full   (q_full)
    );

    // short queue decoupling front and back
    bggi_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .head_item (q_head),
        .empty     (q_empty)
    );

    // back: store writes, corner reads, blend, output register
    bggi_back #(
        .MAX_NX (MAX_NX),
        .MAX_NY (MAX_NY)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_item    (q_head),
        .q_pop     (q_pop),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_oor   (m_tuser),
        .busy      (back_busy)
    );

    // out-of-range results carry zero gradients
    `BGGI_CHECK(a_oor_zero, aclk, aresetn, (m_tvalid && m_tuser) |-> (m_tdata == '0))
    // first cycle out of reset shows no result
    `BGGI_CHECK(a_reset_quiet, aclk, aresetn, $past(!aresetn) |-> !m_tvalid)
    // an idle back with nothing queued cannot raise a result
    `BGGI_CHECK(a_no_spurious, aclk, aresetn, (!back_busy && q_empty) |=> !$rose(m_tvalid))
    // the front never pushes into a full queue
    `BGGI_NEVER(a_push_full, aclk, aresetn, q_push && q_full)

endmodule

// File: tb/sv/testbench.sv
module testbench;
    import bggi_pkg::*;

    // grid geometry of the default build
    localparam int GRID_W = DEF_MAX_NX;
    localparam int GRID_H = DEF_MAX_NY;
    localparam int GRID_N = GRID_W * GRID_H;

    // timing of the bench
    localparam int RESET_CYCLES  = 7;
    localparam int IDLE_PCT      = 32;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 3000;
    localparam int PHASE_WORDS   = 165;

    // register indexes the block has no register behind
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(7);

    // handy Q16.16 values
    localparam logic [DATA_W-1:0] SAMPLE_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAMPLE_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] Q_ONE      = 32'h0001_0000;
    localparam logic [DATA_W-1:0] Q_HALF     = 32'h0000_8000;

    typedef longint unsigned u64_t;

    // input tdata layout, listed from the top bit down
    typedef struct packed {
        logic [IN_TDATA_W-2*IDX_W-4*DATA_W-1:0] pad;
        logic [DATA_W-1:0]                      qy;
        logic [DATA_W-1:0]                      qx;
        logic [DATA_W-1:0]                      vdy;
        logic [DATA_W-1:0]                      vdx;
        logic [IDX_W-1:0]                       row;
        logic [IDX_W-1:0]                       col;
    } in_data_t;

    // one expected result word
    typedef struct packed {
        logic [DATA_W-1:0] gx;
        logic [DATA_W-1:0] gy;
        logic              oor;
    } grad_t;

    // keeps its own copy of the grid and the registers, predicts every query
    class grad_scoreboard;
        logic [DATA_W-1:0]        org_x, org_y, inv_x, inv_y;
        logic [CNT_W-1:0]         cells_x, cells_y;
        logic signed [DATA_W-1:0] dx_mem [GRID_N];
        logic signed [DATA_W-1:0] dy_mem [GRID_N];
        grad_t                    pending_grads[$];
        int                       errors;

        function new();
            org_x = '0;
            org_y = '0;
            inv_x = INV_STEP_RST;
            inv_y = INV_STEP_RST;
            cells_x = CELLS_RST;
            cells_y = CELLS_RST;
            errors = 0;
            foreach (dx_mem[i]) begin
                dx_mem[i] = '0;
                dy_mem[i] = '0;
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
            case (idx)
                REG_ORIGIN_X:   org_x = data;
                REG_ORIGIN_Y:   org_y = data;
                REG_INV_STEP_X: inv_x = data;
                REG_INV_STEP_Y: inv_y = data;
                REG_CELLS_X:    cells_x = data[CNT_W-1:0];
                REG_CELLS_Y:    cells_y = data[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        function u64_t eff_cells(logic [CNT_W-1:0] c, int maxn);
            if (c < 2) return 2;
            if (c > maxn) return u64_t'(maxn);
            return u64_t'(c);
        endfunction

        // lower grid index and fraction along one axis, 0 when off the grid
        function bit locate(logic [DATA_W-1:0] q, logic [DATA_W-1:0] org,
                            logic [DATA_W-1:0] inv, u64_t n,
                            output u64_t lo, output longint t);
            longint d;
            u64_t   lim, p, u;
            d = longint'($signed(q)) - longint'($signed(org));
            lim = n << (2 * FRAC_BITS);
            lo = 0;
            t = 0;
            if (d < 0) return 0;
            if (u64_t'(d) > lim) return 0;
            if (d > 0 && u64_t'(inv) > lim / u64_t'(d)) return 0;
            p = u64_t'(d) * u64_t'(inv);
            u = p >> FRAC_BITS;
            lo = u >> FRAC_BITS;
            if (lo > n - 2) lo = n - 2;
            t = longint'(u - (lo << FRAC_BITS));
            return 1;
        endfunction

        function bit find_cell(logic [DATA_W-1:0] qx, logic [DATA_W-1:0] qy,
                               output int lx, output int ly,
                               output longint tx, output longint ty);
            u64_t lo;
            lx = 0;
            ly = 0;
            ty = 0;
            if (!locate(qx, org_x, inv_x, eff_cells(cells_x, GRID_W), lo, tx)) return 0;
            lx = int'(lo);
            if (!locate(qy, org_y, inv_y, eff_cells(cells_y, GRID_H), lo, ty)) return 0;
            ly = int'(lo);
            return 1;
        endfunction

        // one blend step, rounded toward minus infinity
        function longint lerp(longint a, longint b, longint t);
            longint one;
            one = longint'(1) << FRAC_BITS;
            return (a * (one - t) + b * t) >>> FRAC_BITS;
        endfunction

        function logic [DATA_W-1:0] clip32(longint v);
            if (v > 64'sd2147483647) return SAMPLE_MAX;
            if (v < -64'sd2147483648) return SAMPLE_MIN;
            return v[DATA_W-1:0];
        endfunction

        // x first, then y, on the dx or the dy plane
        function logic [DATA_W-1:0] bilinear_at(bit pick_dy, int lx, int ly,
                                                longint tx, longint ty);
            longint c00, c10, c01, c11;
            int     i0, i1;
            i0 = ly * GRID_W + lx;
            i1 = i0 + GRID_W;
            c00 = pick_dy ? dy_mem[i0] : dx_mem[i0];
            c10 = pick_dy ? dy_mem[i0 + 1] : dx_mem[i0 + 1];
            c01 = pick_dy ? dy_mem[i1] : dx_mem[i1];
            c11 = pick_dy ? dy_mem[i1 + 1] : dx_mem[i1 + 1];
            return clip32(lerp(lerp(c00, c10, tx), lerp(c01, c11, tx), ty));
        endfunction

        function void note_word(logic op, in_data_t d);
            int     lx, ly;
            longint tx, ty;
            grad_t  g;
            if (op == OP_WRITE) begin
                dx_mem[int'(d.row) * GRID_W + int'(d.col)] = d.vdx;
                dy_mem[int'(d.row) * GRID_W + int'(d.col)] = d.vdy;
                return;
            end
            g = '0;
            if (find_cell(d.qx, d.qy, lx, ly, tx, ty)) begin
                g.gx = bilinear_at(1'b0, lx, ly, tx, ty);
                g.gy = bilinear_at(1'b1, lx, ly, tx, ty);
            end else begin
                g.oor = 1'b1;
            end
            pending_grads.push_back(g);
        endfunction

        function void check_word(logic [DATA_W-1:0] gx, logic [DATA_W-1:0] gy, logic oor);
            grad_t want;
            if (pending_grads.size() == 0) begin
                $display("%0t unexpected result: expected none actual %h %h %b",
                         $time, gx, gy, oor);
                errors++;
                return;
            end
            want = pending_grads.pop_front();
            if (gx !== want.gx) begin
                $display("%0t grad_x mismatch: expected %h actual %h", $time, want.gx, gx);
                errors++;
            end
            if (gy !== want.gy) begin
                $display("%0t grad_y mismatch: expected %h actual %h", $time, want.gy, gy);
                errors++;
            end
            if (oor !== want.oor) begin
                $display("%0t out_of_range mismatch: expected %b actual %b",
                         $time, want.oor, oor);
                errors++;
            end
        endfunction

        function int pending_count();
            return pending_grads.size();
        endfunction
    endclass

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [DATA_W-1:0]       cfg_data;
    logic                    s_tvalid;
    logic                    s_tready;
    // entry_col, entry_row, value_dx, value_dy, query_x, query_y, zero pad
    logic [IN_TDATA_W-1:0]   s_tdata;
    // opcode
    logic                    s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    // grad_x, grad_y
    logic [OUT_TDATA_W-1:0]  m_tdata;
    // out_of_range
    logic                    m_tuser;

    in_data_t       s_fields;
    grad_scoreboard sb = new();

    // generator's view of which grid points hold a sample
    bit sample_set [GRID_N];
    // no idling on either side while set
    bit calm = 1'b0;
    // asks the result side for one long hold-off
    bit hold_req = 1'b0;
    int sent = 0;
    int idle_cycles = 0;

    assign s_fields = s_tdata;

    bilinear_gradient_grid_interp_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    // sample both handshakes at the edge; inputs only change via nba
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_word(s_tuser, s_fields);
            if (m_tvalid && m_tready)
                sb.check_word(m_tdata[DATA_W-1:0], m_tdata[2*DATA_W-1:DATA_W], m_tuser);
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: random back-pressure, one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // offer one word, with random gaps ahead of it, and wait for the accept
    task automatic push_word(input logic op, input in_data_t d);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tuser <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
    endtask

    function automatic logic [DATA_W-1:0] rand_sample();
        case ($urandom_range(7))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return $urandom_range(32'h0003_0000);
            3: return -$urandom_range(32'h0003_0000);
            default: return $urandom;
        endcase
    endfunction

    // sample write; query fields carry random noise
    task automatic write_sample(input int col, input int row,
                                input logic [DATA_W-1:0] vdx, input logic [DATA_W-1:0] vdy);
        in_data_t d;
        d = '0;
        d.col = IDX_W'(col);
        d.row = IDX_W'(row);
        d.vdx = vdx;
        d.vdy = vdy;
        d.qx = $urandom;
        d.qy = $urandom;
        sample_set[row * GRID_W + col] = 1'b1;
        push_word(OP_WRITE, d);
    endtask

    // query; any corner not yet written gets a sample first
    task automatic query_point(input logic [DATA_W-1:0] qx, input logic [DATA_W-1:0] qy);
        in_data_t d;
        int       lx, ly;
        longint   tx, ty;
        if (sb.find_cell(qx, qy, lx, ly, tx, ty)) begin
            for (int r = ly; r <= ly + 1; r++) begin
                for (int c = lx; c <= lx + 1; c++) begin
                    if (!sample_set[r * GRID_W + c])
                        write_sample(c, r, rand_sample(), rand_sample());
                end
            end
        end
        d = '0;
        d.col = IDX_W'($urandom);
        d.row = IDX_W'($urandom);
        d.vdx = $urandom;
        d.vdy = $urandom;
        d.qx = qx;
        d.qy = qy;
        push_word(OP_QUERY, d);
    endtask

    // coordinate mostly inside the domain, with its edges and some misses
    function automatic logic [DATA_W-1:0] pick_coord(logic [DATA_W-1:0] org,
                                                     logic [DATA_W-1:0] inv,
                                                     logic [CNT_W-1:0] cells);
        u64_t span, off, n;
        n = sb.eff_cells(cells, GRID_W);
        span = (inv == 0) ? (u64_t'(1) << 20) : (n << (2 * FRAC_BITS)) / u64_t'(inv);
        if (span > (u64_t'(1) << 33)) span = u64_t'(1) << 33;
        case ($urandom_range(9))
            0: off = 0;
            1: off = span;
            2: return $urandom;
            3: off = span + $urandom_range(1, 4);
            4: off = -u64_t'($urandom_range(1, 4));
            default: off = {$urandom, $urandom} % (span + 1);
        endcase
        return org + off[DATA_W-1:0];
    endfunction

    // stop offering and wait until every query has answered
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_count() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        sb.set_reg(idx, data);
    endtask

    // new grid setting, only once the block has gone quiet
    task automatic set_grid(input logic [DATA_W-1:0] ox, input logic [DATA_W-1:0] oy,
                            input logic [DATA_W-1:0] ix, input logic [DATA_W-1:0] iy,
                            input logic [CNT_W-1:0] cx, input logic [CNT_W-1:0] cy);
        drain();
        // a trailing write may still be in flight
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_reg(REG_SPARE_LO, $urandom);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_INV_STEP_X, ix);
        write_reg(REG_INV_STEP_Y, iy);
        write_reg(REG_CELLS_X, DATA_W'(cx));
        write_reg(REG_CELLS_Y, DATA_W'(cy));
        write_reg(REG_SPARE_HI, $urandom);
        cfg_we <= 1'b0;
    endtask

    // mostly queries around the grid, a quarter random sample writes
    task automatic run_random(input int n_words);
        int start;
        start = sent;
        while (sent - start < n_words) begin
            if ($urandom_range(99) < 25) begin
                write_sample($urandom_range(GRID_W - 1), $urandom_range(GRID_H - 1),
                             rand_sample(), rand_sample());
            end else begin
                query_point(pick_coord(sb.org_x, sb.inv_x, sb.cells_x),
                            pick_coord(sb.org_y, sb.inv_y, sb.cells_y));
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_WRITE;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed words on the reset grid: 64x64 points, step 1.0, origin 0
        write_sample(0, 0, SAMPLE_MAX, SAMPLE_MIN);
        write_sample(1, 0, SAMPLE_MIN, SAMPLE_MAX);
        write_sample(0, 1, Q_ONE, -Q_ONE);
        write_sample(1, 1, 0, 32'h7FFF_0000);
        query_point(Q_HALF, Q_HALF);
        // point exactly on the origin
        query_point(0, 0);
        // top corner cell with extreme samples, so extrapolation saturates
        write_sample(62, 62, SAMPLE_MAX, SAMPLE_MIN);
        write_sample(63, 62, SAMPLE_MIN, SAMPLE_MAX);
        write_sample(62, 63, SAMPLE_MAX, SAMPLE_MIN);
        write_sample(63, 63, SAMPLE_MIN, SAMPLE_MAX);
        // point on the upper domain edge, fraction 2.0
        query_point(32'h0040_0000, 32'h0040_0000);
        query_point(32'h003F_8000, 32'h003F_0000);
        // just below the origin and just past the upper edge
        query_point(32'hFFFF_FFFF, Q_HALF);
        query_point(Q_HALF, 32'h0040_0001);
        query_point(SAMPLE_MIN, SAMPLE_MAX);
        query_point(SAMPLE_MAX, SAMPLE_MIN);
        query_point(Q_ONE, Q_ONE);

        // small grid; the result side holds off while words keep coming
        set_grid(0, 0, Q_ONE, Q_ONE, 4, 4);
        run_random(20);
        hold_req = 1'b1;
        run_random(PHASE_WORDS - 20);

        // offset origin, uneven steps, no idling on either side
        calm = 1'b1;
        set_grid(32'hFFFA_8000, 32'h0003_4000, 32'h0002_0000, 32'h0000_8000, 8, 3);
        run_random(PHASE_WORDS);
        calm = 1'b0;

        // extreme origins and inverse steps
        set_grid(SAMPLE_MIN, 32'h7FFF_0000, 32'hFFFF_FFFF, 32'h0000_0001, 2, 64);
        run_random(PHASE_WORDS);

        // cell counts below the minimum and above the maximum
        set_grid(Q_ONE, -Q_ONE, Q_ONE, 32'h0003_0000, 0, 127);
        run_random(PHASE_WORDS);

        // zero inverse step along x, cell counts one and past the maximum
        set_grid(32'h1234_5678, 32'hFEDC_BA98, 0, 32'h0001_8000, 1, 100);
        run_random(PHASE_WORDS);

        // full grid at a random origin; sender waits for every result midway
        set_grid(32'($urandom_range(32'h7FFF_FFFF)) - 32'h4000_0000,
                 32'($urandom_range(32'h7FFF_FFFF)) - 32'h4000_0000, Q_ONE, Q_ONE, 64, 64);
        run_random(80);
        drain();
        run_random(PHASE_WORDS - 80);

        set_grid(SAMPLE_MAX, SAMPLE_MIN, 32'h0000_0001, 32'hFFFF_FFFF, 5, 2);
        run_random(PHASE_WORDS);

        // random small grids
        repeat (3) begin
            set_grid($urandom, $urandom,
                     $urandom_range(32'h0004_0000, 32'h0000_4000),
                     $urandom_range(32'h0004_0000, 32'h0000_4000),
                     CNT_W'($urandom_range(10, 2)), CNT_W'($urandom_range(10, 2)));
            run_random(PHASE_WORDS);
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_count() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
